>>> hw/rtl/wav_pkg.sv
// Package for the WAVE PCM stream parser: result kinds, error codes, header
// byte positions, chunk tags and the 8-bit sample conversion table.
// Depends on nothing; used by wav_pcm_stream_parser.
`default_nettype none

package wav_pkg;

	// Kind of result item
	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_FRAME  = 2'd1,
		KIND_ERROR  = 2'd2
	} result_kind_t;

	// Error codes carried by an error item
	typedef enum logic [3:0] {
		ERR_RIFF      = 4'd0,
		ERR_WAVE      = 4'd1,
		ERR_FMT_TAG   = 4'd2,
		ERR_FMT_SIZE  = 4'd3,
		ERR_NOT_PCM   = 4'd4,
		ERR_CHANNELS  = 4'd5,
		ERR_BITS      = 4'd6,
		ERR_DATA_TAG  = 4'd7,
		ERR_TRUNCATED = 4'd8
	} error_code_t;

	// Header byte index of the last byte of each checked or captured field
	localparam logic [5:0] POS_RIFF     = 6'd3;
	localparam logic [5:0] POS_WAVE     = 6'd11;
	localparam logic [5:0] POS_FMT_TAG  = 6'd15;
	localparam logic [5:0] POS_FMT_SIZE = 6'd19;
	localparam logic [5:0] POS_FORMAT   = 6'd21;
	localparam logic [5:0] POS_CHANNELS = 6'd23;
	localparam logic [5:0] POS_RATE     = 6'd27;
	localparam logic [5:0] POS_BITS     = 6'd35;
	localparam logic [5:0] POS_DATA_TAG = 6'd39;
	localparam logic [5:0] POS_DATA_LEN = 6'd43;

	// Chunk tags as little-endian words
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [31:0] FMT_SIZE_PCM = 32'd16;
	localparam logic [15:0] FORMAT_PCM   = 16'd1;

	// 8-bit code c -> round-half-away((2c-255)*32767/255), built at elaboration
	typedef logic [15:0] conv8_lut_t [256];

	function automatic conv8_lut_t build_conv8_lut();
		conv8_lut_t t;
		int d;
		int q;
		for (int c = 0; c < 256; c++) begin
			if (2 * c < 255) begin
				d = 255 - 2 * c;
				q = (2 * d * 32767 + 255) / 510;
				t[c] = 16'(0 - q);
			end else begin
				d = 2 * c - 255;
				q = (2 * d * 32767 + 255) / 510;
				t[c] = 16'(q);
			end
		end
		return t;
	endfunction

	localparam conv8_lut_t CONV8_LUT = build_conv8_lut();

endpackage

`default_nettype wire

>>> hw/rtl/wav_pcm_stream_parser.sv
// WAVE PCM stream parser: checks the canonical 44-byte PCM header and
// decodes sample frames, one file byte per item.
// Depends on wav_pkg.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  in      | input     | in_valid / in_stall | data_byte, stream_end
//  out     | output    | out_valid/out_stall | result_kind, sample_rate,
//          |           |                     | channel_count, sample_bits,
//          |           |                     | frame_count, left_sample,
//          |           |                     | right_sample, last_frame,
//          |           |                     | error_code
//
// One item per cycle unless out_stall holds a result: an input register, then the
// parse logic updates the header/data state and loads the result register.
// arst_n clears all control state; the parser starts at header byte 0.
// out_stall holds the result register; in_stall rises only when an item
// waits in the input register behind a held result.
`default_nettype none

module wav_pcm_stream_parser (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         data_byte,
	input  wire logic               stream_end,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              result_kind,
	output logic [31:0]             sample_rate,
	output logic [1:0]              channel_count,
	output logic [4:0]              sample_bits,
	output logic [31:0]             frame_count,
	output logic signed [15:0]      left_sample,
	output logic signed [15:0]      right_sample,
	output logic                    last_frame,
	output logic [3:0]              error_code
);

	typedef enum logic [3:0] {
		PH_HEADER = 4'b0001,
		PH_DATA   = 4'b0010,
		PH_DONE   = 4'b0100,
		PH_ERROR  = 4'b1000
	} phase_t;

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	// Parser state
	phase_t      phase_q, phase_d;
	logic [5:0]  pos_q, pos_d;
	logic [31:0] acc_q, acc_d;
	logic [1:0]  chan_q, chan_d;
	logic [4:0]  bits_q, bits_d;
	logic [31:0] rate_q, rate_d;
	logic [31:0] frames_q, frames_d;
	logic [23:0] partial_q, partial_d;
	logic [1:0]  fbi_q, fbi_d;

	// Result register
	logic               out_valid_s2;
	wav_pkg::result_kind_t kind_s2;
	logic [31:0]        rate_s2;
	logic [1:0]         chan_s2;
	logic [4:0]         bits_s2;
	logic [31:0]        frames_s2;
	logic [15:0]        left_s2;
	logic [15:0]        right_s2;
	logic               last_s2;
	wav_pkg::error_code_t err_s2;

	// Next result
	logic               res_vld;
	wav_pkg::result_kind_t res_kind;
	logic [31:0]        res_rate;
	logic [1:0]         res_chan;
	logic [4:0]         res_bits;
	logic [31:0]        res_frames;
	logic [15:0]        res_left;
	logic [15:0]        res_right;
	logic               res_last;
	wav_pkg::error_code_t res_err;

	logic        err_hit;
	wav_pkg::error_code_t err_sel;
	logic [31:0] acc_new;
	logic [15:0] half;
	logic [1:0]  bpf_sh;
	logic [2:0]  bpf;
	logic        advance;
	logic        out_free;

	// Handshake: the input register moves on whenever the result slot frees
	assign out_free = !out_valid_s2 || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			end_s1  <= stream_end;
		end
	end

	// Shared field views
	assign acc_new = {byte_s1, acc_q[31:8]};
	assign half    = acc_new[31:16];
	// bytes per frame = channels * bytes per sample, a power of two
	assign bpf_sh  = {1'b0, chan_q == 2'd2} + {1'b0, bits_q == 5'd16};
	assign bpf     = 3'(3'd1 << bpf_sh);

	// Parse logic for the item in the input register
	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		acc_d     = acc_q;
		chan_d    = chan_q;
		bits_d    = bits_q;
		rate_d    = rate_q;
		frames_d  = frames_q;
		partial_d = partial_q;
		fbi_d     = fbi_q;

		res_vld    = 1'b0;
		res_kind   = wav_pkg::KIND_HEADER;
		res_rate   = '0;
		res_chan   = '0;
		res_bits   = '0;
		res_frames = '0;
		res_left   = '0;
		res_right  = '0;
		res_last   = 1'b0;
		res_err    = wav_pkg::ERR_RIFF;

		err_hit = 1'b0;
		err_sel = wav_pkg::ERR_RIFF;

		if (end_s1) begin
			// end of file: re-arm, flag truncation if still parsing
			phase_d   = PH_HEADER;
			pos_d     = '0;
			acc_d     = '0;
			chan_d    = '0;
			bits_d    = '0;
			rate_d    = '0;
			frames_d  = '0;
			partial_d = '0;
			fbi_d     = '0;
			if (phase_q == PH_HEADER || phase_q == PH_DATA) begin
				res_vld  = 1'b1;
				res_kind = wav_pkg::KIND_ERROR;
				res_err  = wav_pkg::ERR_TRUNCATED;
			end
		end else begin
			case (phase_q)
				PH_HEADER: begin
					acc_d = acc_new;
					pos_d = pos_q + 6'd1;
					case (pos_q)
						wav_pkg::POS_RIFF: begin
							if (acc_new != wav_pkg::TAG_RIFF) begin
								err_hit = 1'b1;
								err_sel = wav_pkg::ERR_RIFF;
							end
						end
						wav_pkg::POS_WAVE: begin
							if (acc_new != wav_pkg::TAG_WAVE) begin
								err_hit = 1'b1;
								err_sel = wav_pkg::ERR_WAVE;
							end
						end
						wav_pkg::POS_FMT_TAG: begin
							if (acc_new != wav_pkg::TAG_FMT) begin
								err_hit = 1'b1;
								err_sel = wav_pkg::ERR_FMT_TAG;
							end
						end
						wav_pkg::POS_FMT_SIZE: begin
							if (acc_new != wav_pkg::FMT_SIZE_PCM) begin
								err_hit = 1'b1;
								err_sel = wav_pkg::ERR_FMT_SIZE;
							end
						end
						wav_pkg::POS_FORMAT: begin
							if (half != wav_pkg::FORMAT_PCM) begin
								err_hit = 1'b1;
								err_sel = wav_pkg::ERR_NOT_PCM;
							end
						end
						wav_pkg::POS_CHANNELS: begin
							if (!(half inside {16'd1, 16'd2})) begin
								err_hit = 1'b1;
								err_sel = wav_pkg::ERR_CHANNELS;
							end else begin
								chan_d = half[1:0];
							end
						end
						wav_pkg::POS_RATE: begin
							rate_d = acc_new;
						end
						wav_pkg::POS_BITS: begin
							if (!(half inside {16'd8, 16'd16})) begin
								err_hit = 1'b1;
								err_sel = wav_pkg::ERR_BITS;
							end else begin
								bits_d = half[4:0];
							end
						end
						wav_pkg::POS_DATA_TAG: begin
							if (acc_new != wav_pkg::TAG_DATA) begin
								err_hit = 1'b1;
								err_sel = wav_pkg::ERR_DATA_TAG;
							end
						end
						wav_pkg::POS_DATA_LEN: begin
							// data size over bytes per frame
							frames_d   = acc_new >> bpf_sh;
							partial_d  = '0;
							fbi_d      = '0;
							phase_d    = (frames_d != '0) ? PH_DATA : PH_DONE;
							res_vld    = 1'b1;
							res_kind   = wav_pkg::KIND_HEADER;
							res_rate   = rate_q;
							res_chan   = chan_q;
							res_bits   = bits_q;
							res_frames = frames_d;
						end
						default: ;
					endcase
					if (err_hit) begin
						phase_d  = PH_ERROR;
						res_vld  = 1'b1;
						res_kind = wav_pkg::KIND_ERROR;
						res_err  = err_sel;
					end
				end
				PH_DATA: begin
					if ({1'b0, fbi_q} + 3'd1 < bpf) begin
						// collect earlier bytes of the frame
						case (fbi_q)
							2'd0:    partial_d[7:0]   = byte_s1;
							2'd1:    partial_d[15:8]  = byte_s1;
							2'd2:    partial_d[23:16] = byte_s1;
							default: ;
						endcase
						fbi_d = fbi_q + 2'd1;
					end else begin
						// last byte of the frame: decode and emit
						if (bits_q == 5'd8) begin
							if (chan_q == 2'd1) begin
								res_left  = wav_pkg::CONV8_LUT[byte_s1];
								res_right = wav_pkg::CONV8_LUT[byte_s1];
							end else begin
								res_left  = wav_pkg::CONV8_LUT[partial_q[7:0]];
								res_right = wav_pkg::CONV8_LUT[byte_s1];
							end
						end else begin
							if (chan_q == 2'd1) begin
								res_left  = {byte_s1, partial_q[7:0]};
								res_right = {byte_s1, partial_q[7:0]};
							end else begin
								res_left  = partial_q[15:0];
								res_right = {byte_s1, partial_q[23:16]};
							end
						end
						partial_d = '0;
						fbi_d     = '0;
						frames_d  = frames_q - 32'd1;
						res_vld   = 1'b1;
						res_kind  = wav_pkg::KIND_FRAME;
						res_rate  = rate_q;
						res_chan  = chan_q;
						res_bits  = bits_q;
						res_last  = (frames_q == 32'd1);
						if (frames_q == 32'd1) begin
							phase_d = PH_DONE;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			pos_q     <= '0;
			acc_q     <= '0;
			chan_q    <= '0;
			bits_q    <= '0;
			rate_q    <= '0;
			frames_q  <= '0;
			partial_q <= '0;
			fbi_q     <= '0;
		end else if (advance) begin
			phase_q   <= phase_d;
			pos_q     <= pos_d;
			acc_q     <= acc_d;
			chan_q    <= chan_d;
			bits_q    <= bits_d;
			rate_q    <= rate_d;
			frames_q  <= frames_d;
			partial_q <= partial_d;
			fbi_q     <= fbi_d;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= res_vld;
		end else if (!out_stall) begin
			out_valid_s2 <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (advance && res_vld) begin
			kind_s2   <= res_kind;
			rate_s2   <= res_rate;
			chan_s2   <= res_chan;
			bits_s2   <= res_bits;
			frames_s2 <= res_frames;
			left_s2   <= res_left;
			right_s2  <= res_right;
			last_s2   <= res_last;
			err_s2    <= (res_kind == wav_pkg::KIND_ERROR) ? res_err : wav_pkg::ERR_RIFF;
		end
	end

	assign out_valid     = out_valid_s2;
	assign result_kind   = kind_s2;
	assign sample_rate   = rate_s2;
	assign channel_count = chan_s2;
	assign sample_bits   = bits_s2;
	assign frame_count   = frames_s2;
	assign left_sample   = left_s2;
	assign right_sample  = right_s2;
	assign last_frame    = last_s2;
	assign error_code    = err_s2;

endmodule

`default_nettype wire
